// ===== src/rtpm_pkg.sv =====
// Shared types and constants for the RTP extension mask-field parser.
package rtpm_pkg;

    localparam logic [7:0]  MASK_BW      = 8'h01;
    localparam logic [7:0]  MASK_FEC     = 8'h1E;
    localparam logic [7:0]  MASK_VAD     = 8'h20;
    localparam logic [7:0]  MASK_TIME    = 8'h40;
    localparam logic [7:0]  MASK_BN      = 8'h80;
    localparam int          COUNT_W      = 18;
    localparam logic [17:0] COUNT_MAX    = 18'h3FFFF;
    localparam logic [15:0] TIME_BYTES   = 16'd4;

    typedef enum logic [3:0] {
        PH_H0       = 4'd0,
        PH_H1       = 4'd1,
        PH_H2       = 4'd2,
        PH_H3       = 4'd3,
        PH_BWS_HI   = 4'd4,
        PH_BWS_LO   = 4'd5,
        PH_FECS_HI  = 4'd6,
        PH_FECS_LO  = 4'd7,
        PH_BNS      = 4'd8,
        PH_BW_DATA  = 4'd9,
        PH_FEC_DATA = 4'd10,
        PH_VAD      = 4'd11,
        PH_TIME     = 4'd12,
        PH_BN_DATA  = 4'd13,
        PH_DONE     = 4'd14
    } t_phase;

    typedef enum logic [1:0] {
        SEC_BW  = 2'd0,
        SEC_FEC = 2'd1,
        SEC_BN  = 2'd2
    } t_section;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNC     = 2'd2
    } t_status;

    typedef struct packed {
        logic        is_summary;
        logic [1:0]  section;
        logic [7:0]  payload_byte;
        logic [4:0]  fec_kind;
        logic [15:0] bandwidth_len;
        logic [15:0] fec_len;
        logic [7:0]  bounced_len;
        logic        has_vad;
        logic [7:0]  vad_value;
        logic        has_orig_time;
        logic [31:0] orig_time;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== src/rtpm_if.sv =====
// Request channel interfaces: extension bytes in, parsed results out.
interface rtpm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtpm_out_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [1:0]  section;
    logic [7:0]  payload_byte;
    logic [4:0]  fec_kind;
    logic [15:0] bandwidth_len;
    logic [15:0] fec_len;
    logic [7:0]  bounced_len;
    logic        has_vad;
    logic [7:0]  vad_value;
    logic        has_orig_time;
    logic [31:0] orig_time;
    logic [1:0]  status;

    modport source (
        output valid, output is_summary, output section, output payload_byte,
        output fec_kind, output bandwidth_len, output fec_len, output bounced_len,
        output has_vad, output vad_value, output has_orig_time, output orig_time,
        output status, input ready
    );
    modport sink (
        input valid, input is_summary, input section, input payload_byte,
        input fec_kind, input bandwidth_len, input fec_len, input bounced_len,
        input has_vad, input vad_value, input has_orig_time, input orig_time,
        input status, output ready
    );
endinterface

// ===== src/rtp_ext_mask_field_parser.sv =====
// Top level: RTP header-extension mask-field parser.
//
// i_in carries the extension one byte per request, last_byte set on the
// final byte. o_out returns results: a payload request for every bandwidth,
// FEC or bounced-timestamp data byte (tagged by section), and a summary
// request (is_summary = 1) after the final byte carrying the decoded sizes,
// VAD byte, original timestamp and status. On a non-zero status all decoded
// fields are zero and earlier payload requests of that extension are to be
// dropped by the receiver.
//
// An accepted byte waits in the input register until its results fit the queue.
// Throughput: one byte per cycle while the receiver does not stall; a final
// byte that is also a data byte yields two results. The limit is the
// single-result output port fed from a two-entry result queue.
//
// Reset (synchronous, active low) returns the parser to header byte zero
// and empties the input register and queue. When the receiver stalls, the
// queue fills and i_in.ready drops once a byte's results no longer fit.
module rtp_ext_mask_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtpm_in_if.sink     i_in,
    rtpm_out_if.source  o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    rtpm_pkg::t_phase                 r_phase, n_phase;
    logic [rtpm_pkg::COUNT_W-1:0]     r_count_b, n_count_b;
    logic [7:0]                       r_mask_count, n_mask_count;
    logic [7:0]                       r_mask_bits, n_mask_bits;
    logic [15:0]                      r_bw_len, n_bw_len;
    logic [15:0]                      r_fec_len, n_fec_len;
    logic [7:0]                       r_bn_len, n_bn_len;
    logic [15:0]                      r_left, n_left;
    logic                             r_has_vad, n_has_vad;
    logic [7:0]                       r_vad, n_vad;
    logic                             r_has_time, n_has_time;
    logic [31:0]                      r_time, n_time;

    // result queue
    rtpm_pkg::t_result r_slot0, r_slot1, n_slot0, n_slot1;
    logic [1:0]        r_qcount, n_qcount;

    logic              adv;
    logic              pay_valid;
    rtpm_pkg::t_section pay_sec;
    logic              malformed;
    rtpm_pkg::t_status sum_status;
    rtpm_pkg::t_result res_pay, res_sum, res_a, res_b;
    logic [1:0]        n_res;
    logic [1:0]        kept;
    logic              pop;
    logic              fire;

    function automatic logic phase_present(
        input logic [3:0]  p,
        input logic [7:0]  mbits,
        input logic [15:0] bw,
        input logic [15:0] fec,
        input logic [7:0]  bn
    );
        logic pres;
        pres = 1'b1;
        case (rtpm_pkg::t_phase'(p))
            rtpm_pkg::PH_BWS_HI,
            rtpm_pkg::PH_BWS_LO:   pres = (mbits & rtpm_pkg::MASK_BW) != 8'd0;
            rtpm_pkg::PH_FECS_HI,
            rtpm_pkg::PH_FECS_LO:  pres = (mbits & rtpm_pkg::MASK_FEC) != 8'd0;
            rtpm_pkg::PH_BNS:      pres = (mbits & rtpm_pkg::MASK_BN) != 8'd0;
            rtpm_pkg::PH_BW_DATA:  pres = bw != 16'd0;
            rtpm_pkg::PH_FEC_DATA: pres = fec != 16'd0;
            rtpm_pkg::PH_VAD:      pres = (mbits & rtpm_pkg::MASK_VAD) != 8'd0;
            rtpm_pkg::PH_TIME:     pres = (mbits & rtpm_pkg::MASK_TIME) != 8'd0;
            rtpm_pkg::PH_BN_DATA:  pres = bn != 8'd0;
            default:               pres = 1'b1;
        endcase
        return pres;
    endfunction

    // first present field phase after cur, else done
    function automatic rtpm_pkg::t_phase next_phase(
        input rtpm_pkg::t_phase cur,
        input logic [7:0]       mbits,
        input logic [15:0]      bw,
        input logic [15:0]      fec,
        input logic [7:0]       bn
    );
        rtpm_pkg::t_phase res;
        logic             found;
        res   = rtpm_pkg::PH_DONE;
        found = 1'b0;
        for (int i = int'(rtpm_pkg::PH_BWS_HI); i <= int'(rtpm_pkg::PH_BN_DATA); i++) begin
            if (!found && (4'(i) > cur) && phase_present(4'(i), mbits, bw, fec, bn)) begin
                res   = rtpm_pkg::t_phase'(4'(i));
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // parser next state and results
    always_comb begin
        n_phase      = r_phase;
        n_count_b    = (r_count_b < rtpm_pkg::COUNT_MAX) ? r_count_b + 1'b1 : r_count_b;
        n_mask_count = r_mask_count;
        n_mask_bits  = r_mask_bits;
        n_bw_len     = r_bw_len;
        n_fec_len    = r_fec_len;
        n_bn_len     = r_bn_len;
        n_left       = r_left;
        n_has_vad    = r_has_vad;
        n_vad        = r_vad;
        n_has_time   = r_has_time;
        n_time       = r_time;
        adv          = 1'b0;
        pay_valid    = 1'b0;
        pay_sec      = rtpm_pkg::SEC_BW;

        unique case (r_phase)
            rtpm_pkg::PH_H0: begin
                n_mask_count = r_in_byte;
                n_phase = (r_in_byte == 8'd0) ? rtpm_pkg::PH_DONE : rtpm_pkg::PH_H1;
            end
            rtpm_pkg::PH_H1: begin
                n_mask_bits = r_in_byte;
                n_phase     = rtpm_pkg::PH_H2;
            end
            rtpm_pkg::PH_H2: n_phase = rtpm_pkg::PH_H3;
            rtpm_pkg::PH_H3: adv = 1'b1;
            rtpm_pkg::PH_BWS_HI: begin
                n_bw_len = {8'd0, r_in_byte};
                adv      = 1'b1;
            end
            rtpm_pkg::PH_BWS_LO: begin
                n_bw_len = {r_bw_len[7:0], r_in_byte};
                adv      = 1'b1;
            end
            rtpm_pkg::PH_FECS_HI: begin
                n_fec_len = {8'd0, r_in_byte};
                adv       = 1'b1;
            end
            rtpm_pkg::PH_FECS_LO: begin
                n_fec_len = {r_fec_len[7:0], r_in_byte};
                adv       = 1'b1;
            end
            rtpm_pkg::PH_BNS: begin
                n_bn_len = r_in_byte;
                adv      = 1'b1;
            end
            rtpm_pkg::PH_BW_DATA, rtpm_pkg::PH_FEC_DATA, rtpm_pkg::PH_BN_DATA: begin
                pay_valid = 1'b1;
                pay_sec   = (r_phase == rtpm_pkg::PH_BW_DATA)  ? rtpm_pkg::SEC_BW  :
                            (r_phase == rtpm_pkg::PH_FEC_DATA) ? rtpm_pkg::SEC_FEC :
                                                                 rtpm_pkg::SEC_BN;
                n_left    = r_left - 16'd1;
                adv       = (n_left == 16'd0);
            end
            rtpm_pkg::PH_VAD: begin
                n_vad     = r_in_byte;
                n_has_vad = 1'b1;
                adv       = 1'b1;
            end
            rtpm_pkg::PH_TIME: begin
                n_time = {r_time[23:0], r_in_byte};
                n_left = r_left - 16'd1;
                if (n_left == 16'd0) begin
                    n_has_time = 1'b1;
                    adv        = 1'b1;
                end
            end
            default: ;
        endcase

        // skipping uses the size fields as updated by this byte
        if (adv) begin
            n_phase = next_phase(r_phase, n_mask_bits, n_bw_len, n_fec_len, n_bn_len);
            case (n_phase)
                rtpm_pkg::PH_BW_DATA:  n_left = n_bw_len;
                rtpm_pkg::PH_FEC_DATA: n_left = n_fec_len;
                rtpm_pkg::PH_TIME:     n_left = rtpm_pkg::TIME_BYTES;
                rtpm_pkg::PH_BN_DATA:  n_left = {8'd0, n_bn_len};
                default: ;
            endcase
        end

        malformed = (n_count_b < 18'd4) || (n_mask_count == 8'd0) ||
                    ((n_count_b - 18'd4) < {10'd0, n_mask_count - 8'd1});
        sum_status = malformed                      ? rtpm_pkg::ST_MALFORMED :
                     (n_phase != rtpm_pkg::PH_DONE) ? rtpm_pkg::ST_TRUNC     :
                                                      rtpm_pkg::ST_OK;

        res_pay              = '0;
        res_pay.section      = pay_sec;
        res_pay.payload_byte = r_in_byte;

        res_sum            = '0;
        res_sum.is_summary = 1'b1;
        res_sum.status     = sum_status;
        if (sum_status == rtpm_pkg::ST_OK) begin
            res_sum.fec_kind      = 5'(n_mask_bits & rtpm_pkg::MASK_FEC);
            res_sum.bandwidth_len = n_bw_len;
            res_sum.fec_len       = n_fec_len;
            res_sum.bounced_len   = n_bn_len;
            res_sum.has_vad       = n_has_vad;
            res_sum.vad_value     = n_vad;
            res_sum.has_orig_time = n_has_time;
            res_sum.orig_time     = n_time;
        end

        res_a = pay_valid ? res_pay : res_sum;
        res_b = res_sum;
        n_res = {1'b0, pay_valid} + {1'b0, r_in_last};
    end

    // handshake and result queue
    assign pop  = o_out.valid && o_out.ready;
    assign kept = r_qcount - {1'b0, pop};
    assign fire = r_in_valid && ({1'b0, kept} + {1'b0, n_res} <= 3'd2);
    assign i_in.ready = !r_in_valid || fire;

    always_comb begin
        rtpm_pkg::t_result head;
        head     = pop ? r_slot1 : r_slot0;
        n_slot0  = (kept != 2'd0) ? head : res_a;
        n_slot1  = (kept == 2'd2) ? r_slot1 : ((kept == 2'd1) ? res_a : res_b);
        n_qcount = kept + (fire ? n_res : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_qcount   <= 2'd0;
        end else begin
            r_qcount <= n_qcount;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_last)) begin
            r_phase      <= rtpm_pkg::PH_H0;
            r_count_b    <= '0;
            r_mask_count <= '0;
            r_mask_bits  <= '0;
            r_bw_len     <= '0;
            r_fec_len    <= '0;
            r_bn_len     <= '0;
            r_left       <= '0;
            r_has_vad    <= 1'b0;
            r_vad        <= '0;
            r_has_time   <= 1'b0;
            r_time       <= '0;
        end else if (fire) begin
            r_phase      <= n_phase;
            r_count_b    <= n_count_b;
            r_mask_count <= n_mask_count;
            r_mask_bits  <= n_mask_bits;
            r_bw_len     <= n_bw_len;
            r_fec_len    <= n_fec_len;
            r_bn_len     <= n_bn_len;
            r_left       <= n_left;
            r_has_vad    <= n_has_vad;
            r_vad        <= n_vad;
            r_has_time   <= n_has_time;
            r_time       <= n_time;
        end
    end

    assign o_out.valid         = (r_qcount != 2'd0);
    assign o_out.is_summary    = r_slot0.is_summary;
    assign o_out.section       = r_slot0.section;
    assign o_out.payload_byte  = r_slot0.payload_byte;
    assign o_out.fec_kind      = r_slot0.fec_kind;
    assign o_out.bandwidth_len = r_slot0.bandwidth_len;
    assign o_out.fec_len       = r_slot0.fec_len;
    assign o_out.bounced_len   = r_slot0.bounced_len;
    assign o_out.has_vad       = r_slot0.has_vad;
    assign o_out.vad_value     = r_slot0.vad_value;
    assign o_out.has_orig_time = r_slot0.has_orig_time;
    assign o_out.orig_time     = r_slot0.orig_time;
    assign o_out.status        = r_slot0.status;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount != 2'd3)
        else $error("result queue overfilled");

    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> ({1'b0, kept} + {1'b0, n_res} <= 3'd2))
        else $error("request processed without queue room");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_phase == rtpm_pkg::PH_H0 && r_count_b == '0))
        else $error("parser did not restart after final byte");

    a_summary_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last && !pay_valid && kept == 2'd0) |=>
            (o_out.valid && o_out.is_summary))
        else $error("summary missing after final byte");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");
`endif

endmodule
